[rtl/core/bed_pkg.sv]
// ----------------------------------------------------------------------------
// bed_pkg: shared types and constants of the keypad event decoder
// Entry layout, request and result codes, search modes and the structs
// passed between the sequencer and the entry compare unit.
// ----------------------------------------------------------------------------
package bed_pkg;

	localparam int KEYS             = 6;   // keys on the pad, key i is bit i
	localparam int EVENTS           = 8;   // table entries searched
	localparam int KEY_W            = 6;   // key field width in samples and entries
	localparam int PAT_W            = KEYS + 1; // key bits plus noisy marker bit
	localparam int IDX_W            = 3;
	localparam int TIMER_W          = 8;
	localparam int SECS_W           = 8;
	localparam int SECS_SCALED_W    = 12;  // seconds in ticks, 255 * 10 fits
	localparam int TICKS_PER_SECOND = 10;
	localparam int ENTRY_W          = 16;
	localparam int WORD_W           = 64;
	localparam int ENTRIES_PER_WORD = WORD_W / ENTRY_W;
	localparam int CFG_IDX_W        = 1;
	localparam int COUNT_W          = $clog2(PAT_W + 1);

	localparam logic [KEY_W-1:0]   KEY_MASK   = KEY_W'((1 << KEYS) - 1);
	localparam logic [PAT_W-1:0]   NOISY_MARK = PAT_W'(1) << KEYS;
	localparam logic [TIMER_W-1:0] TIMER_MAX  = '1;
	localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(EVENTS - 1);

	// entry bit positions
	localparam int ENTRY_PRESS_BIT = 7;
	localparam int ENTRY_SECS_LSB  = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_HIGH = 1'b1;

	// request codes
	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_TICK   = 2'd1;
	localparam logic [1:0] REQ_FORCED = 2'd2;

	// result codes
	localparam logic [1:0] STATUS_NONE    = 2'd0;
	localparam logic [1:0] STATUS_EVENT   = 2'd1;
	localparam logic [1:0] STATUS_ILLEGAL = 2'd2;

	localparam logic [1:0] BEEP_NONE   = 2'd0;
	localparam logic [1:0] BEEP_NORMAL = 2'd1;
	localparam logic [1:0] BEEP_ERROR  = 2'd2;

	typedef enum logic [2:0] {
		MODE_FORCED  = 3'd0,
		MODE_TIMED   = 3'd1,
		MODE_PRESS   = 3'd2,
		MODE_RELEASE = 3'd3,
		MODE_UNUSED  = 3'd4
	} mode_t;

	typedef struct packed {
		logic [KEY_W-1:0]  keys;
		logic              press;
		logic [SECS_W-1:0] secs;
	} entry_t;

	typedef struct packed {
		mode_t              mode;
		logic [PAT_W-1:0]   pat;
		logic               press;
		logic               timed;
		logic [TIMER_W-1:0] timer;
	} match_req_t;

	typedef struct packed {
		logic empty;
		logic hit;
	} match_rsp_t;

endpackage

[rtl/core/bed_event_table.sv]
// ----------------------------------------------------------------------------
// bed_event_table: event table registers
// Holds the two 64-bit table words and returns the decoded entry at rd_idx.
// ----------------------------------------------------------------------------
module bed_event_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [bed_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bed_pkg::WORD_W-1:0]     cfg_data,
	input  logic [bed_pkg::IDX_W-1:0]      rd_idx,
	output bed_pkg::entry_t                rd_entry
);

	logic [bed_pkg::WORD_W-1:0]  table_lo_q;
	logic [bed_pkg::WORD_W-1:0]  table_hi_q;
	logic [bed_pkg::WORD_W-1:0]  word;
	logic [bed_pkg::ENTRY_W-1:0] raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_lo_q <= '0;
			table_hi_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bed_pkg::CFG_TABLE_LOW:  table_lo_q <= cfg_data;
				bed_pkg::CFG_TABLE_HIGH: table_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign word = rd_idx[2] ? table_hi_q : table_lo_q;
	assign raw  = word[rd_idx[1:0] * bed_pkg::ENTRY_W +: bed_pkg::ENTRY_W];

	assign rd_entry.keys  = raw[bed_pkg::KEY_W-1:0] & bed_pkg::KEY_MASK;
	assign rd_entry.press = raw[bed_pkg::ENTRY_PRESS_BIT];
	assign rd_entry.secs  = raw[bed_pkg::ENTRY_SECS_LSB +: bed_pkg::SECS_W];

endmodule

[rtl/core/bed_entry_match.sv]
// ----------------------------------------------------------------------------
// bed_entry_match: shared entry compare unit
// Tests one table entry against the current search; all searches use it.
// ----------------------------------------------------------------------------
module bed_entry_match (
	input  bed_pkg::match_req_t req,
	input  bed_pkg::entry_t     entry,
	output bed_pkg::match_rsp_t rsp
);

	logic [bed_pkg::PAT_W-1:0]         keys_ext;
	logic                              is_timed;
	logic                              same_keys;
	logic [bed_pkg::SECS_SCALED_W-1:0] limit;
	logic                              time_ok;

	assign keys_ext  = bed_pkg::PAT_W'(entry.keys);
	assign is_timed  = (entry.secs != '0);
	assign same_keys = (keys_ext == req.pat);
	assign limit     = bed_pkg::SECS_SCALED_W'(entry.secs)
	                 * bed_pkg::SECS_SCALED_W'(bed_pkg::TICKS_PER_SECOND);
	assign time_ok   = (bed_pkg::SECS_SCALED_W'(req.timer) >= limit);

	always_comb begin
		rsp.empty = (entry.keys == '0);
		unique case (req.mode)
			bed_pkg::MODE_FORCED:  rsp.hit = same_keys && (entry.press == req.press)
			                               && (is_timed == req.timed);
			bed_pkg::MODE_TIMED:   rsp.hit = same_keys && is_timed && time_ok;
			bed_pkg::MODE_PRESS:   rsp.hit = same_keys && entry.press;
			bed_pkg::MODE_RELEASE: rsp.hit = same_keys && !entry.press && !is_timed;
			bed_pkg::MODE_UNUSED:  rsp.hit = ((keys_ext & req.pat) == req.pat);
			default:               rsp.hit = 1'b0;
		endcase
	end

endmodule

[rtl/core/button_event_decoder.sv]
// ----------------------------------------------------------------------------
// button_event_decoder: keypad event decoder
// Debounce check, press / release / hold classification and a sequential
// walk over an eight-entry event table through one shared compare unit.
// ----------------------------------------------------------------------------
//
//  channel | signals                                       | transfer when
//  --------+-----------------------------------------------+------------------------
//  in      | in_valid, in_ready, req_type, sample_first,   | in_valid & in_ready
//          | sample_second, forced_keys, forced_press,     |
//          | forced_timed                                  |
//  out     | out_valid, out_ready, event_status,           | out_valid & out_ready
//          | event_index, beep_kind, pending_flag          |
//  cfg     | cfg_wr_en, cfg_index, cfg_data                | cfg_wr_en (no handshake)
//
// A tick or unused request goes from accept straight to finish. A sample
// goes through the evaluate state and, unless its readings differ or all keys
// stay up, walks the table; a forced request adds its own walk first. A press
// that matches nothing is followed by a second walk for the illegal-key check.
// The single entry compare unit visits one entry a cycle.
// Reset clears the table, the last pattern, the hold timer and the pending flag.
// in_ready is high only in the idle state; a finished result waits in the
// output register while the next item is already being accepted and worked.
// ----------------------------------------------------------------------------
module button_event_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [bed_pkg::KEY_W-1:0]     sample_first,
	input  logic [bed_pkg::KEY_W-1:0]     sample_second,
	input  logic [bed_pkg::KEY_W-1:0]     forced_keys,
	input  logic                          forced_press,
	input  logic                          forced_timed,
	// output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    event_status,
	output logic [bed_pkg::IDX_W-1:0]     event_index,
	output logic [1:0]                    beep_kind,
	output logic                          pending_flag,
	// configuration
	input  logic                          cfg_wr_en,
	input  logic [bed_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bed_pkg::WORD_W-1:0]    cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EVAL   = 4'b0010,
		ST_WALK   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t                          state_q;
	bed_pkg::mode_t                  mode_q;
	logic [bed_pkg::IDX_W-1:0]       idx_q;
	logic [bed_pkg::PAT_W-1:0]       pat_q;     // pattern under search
	logic [bed_pkg::PAT_W-1:0]       chg_q;     // keys that changed, for illegal check
	logic [bed_pkg::PAT_W-1:0]       last_q;    // last clean pattern or noisy marker
	logic [bed_pkg::TIMER_W-1:0]     timer_q;
	logic                            pending_q;
	logic [1:0]                      res_status_q;
	logic [bed_pkg::IDX_W-1:0]       res_idx_q;
	logic [1:0]                      res_beep_q;

	// captured request payload
	logic [bed_pkg::KEY_W-1:0]       samp_a_q;
	logic [bed_pkg::KEY_W-1:0]       samp_b_q;
	logic                            fpress_q;
	logic                            ftimed_q;

	// output register
	logic                            out_valid_q;
	logic [1:0]                      out_status_q;
	logic [bed_pkg::IDX_W-1:0]       out_idx_q;
	logic [1:0]                      out_beep_q;
	logic                            out_pending_q;

	logic                            in_xfer;
	logic                            out_load;
	logic [bed_pkg::PAT_W-1:0]       a_ext;
	logic                            rise;
	bed_pkg::entry_t                 entry;
	bed_pkg::match_req_t             mreq;
	bed_pkg::match_rsp_t             mrsp;
	logic                            found;
	logic                            walk_end;

	function automatic logic [bed_pkg::COUNT_W-1:0] popcount(
		input logic [bed_pkg::PAT_W-1:0] v
	);
		logic [bed_pkg::COUNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < bed_pkg::PAT_W; i++) begin
			n = n + bed_pkg::COUNT_W'(v[i]);
		end
		return n;
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// clean pattern and rise test, the noisy marker counts as one key
	assign a_ext = bed_pkg::PAT_W'(samp_a_q);
	assign rise  = (popcount(last_q) < popcount(a_ext));

	bed_event_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rd_idx    (idx_q),
		.rd_entry  (entry)
	);

	assign mreq.mode  = mode_q;
	assign mreq.pat   = pat_q;
	assign mreq.press = fpress_q;
	assign mreq.timed = ftimed_q;
	assign mreq.timer = timer_q;

	bed_entry_match u_match (
		.req   (mreq),
		.entry (entry),
		.rsp   (mrsp)
	);

	// an empty entry ends the walk before it is tested
	assign found    = mrsp.hit && !mrsp.empty;
	assign walk_end = mrsp.empty || (idx_q == bed_pkg::LAST_IDX);

	// payload capture
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			samp_a_q <= sample_first & bed_pkg::KEY_MASK;
			samp_b_q <= sample_second & bed_pkg::KEY_MASK;
			fpress_q <= forced_press;
			ftimed_q <= forced_timed;
		end
		if (out_load) begin
			out_status_q  <= res_status_q;
			out_idx_q     <= res_idx_q;
			out_beep_q    <= res_beep_q;
			out_pending_q <= pending_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= bed_pkg::MODE_FORCED;
			idx_q        <= '0;
			pat_q        <= '0;
			chg_q        <= '0;
			last_q       <= '0;
			timer_q      <= '0;
			pending_q    <= 1'b0;
			res_status_q <= bed_pkg::STATUS_NONE;
			res_idx_q    <= '0;
			res_beep_q   <= bed_pkg::BEEP_NONE;
			out_valid_q  <= 1'b0;
		end else begin
			// a new result replaces a consumed one in the same cycle
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						res_status_q <= bed_pkg::STATUS_NONE;
						res_idx_q    <= '0;
						res_beep_q   <= bed_pkg::BEEP_NONE;
						idx_q        <= '0;
						case (req_type)
							bed_pkg::REQ_TICK: begin
								if (timer_q < bed_pkg::TIMER_MAX) begin
									timer_q <= timer_q + 1'b1;
								end
								state_q <= ST_FINISH;
							end
							bed_pkg::REQ_SAMPLE: begin
								state_q <= ST_EVAL;
							end
							bed_pkg::REQ_FORCED: begin
								mode_q  <= bed_pkg::MODE_FORCED;
								pat_q   <= bed_pkg::PAT_W'(forced_keys & bed_pkg::KEY_MASK);
								state_q <= ST_WALK;
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_EVAL: begin
					idx_q <= '0;
					if (samp_a_q != samp_b_q) begin
						last_q  <= bed_pkg::NOISY_MARK;
						state_q <= ST_FINISH;
					end else begin
						last_q <= a_ext;
						if (a_ext == last_q) begin
							// held pattern: hold search, nothing for all keys up
							mode_q  <= bed_pkg::MODE_TIMED;
							pat_q   <= a_ext;
							state_q <= (samp_a_q != '0) ? ST_WALK : ST_FINISH;
						end else begin
							timer_q <= '0;
							chg_q   <= last_q ^ a_ext;
							if (rise) begin
								mode_q <= bed_pkg::MODE_PRESS;
								pat_q  <= a_ext;
							end else begin
								mode_q <= bed_pkg::MODE_RELEASE;
								pat_q  <= last_q;
							end
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (found) begin
						unique case (mode_q)
							bed_pkg::MODE_FORCED: begin
								res_status_q <= bed_pkg::STATUS_EVENT;
								res_idx_q    <= idx_q;
							end
							bed_pkg::MODE_UNUSED: begin
								// changed keys are in use: quiet miss
							end
							default: begin
								if (mode_q == bed_pkg::MODE_TIMED) begin
									timer_q <= '0;
								end
								pending_q    <= 1'b0;
								res_status_q <= bed_pkg::STATUS_EVENT;
								res_idx_q    <= idx_q;
								res_beep_q   <= bed_pkg::BEEP_NORMAL;
							end
						endcase
						state_q <= ST_FINISH;
					end else if (walk_end) begin
						unique case (mode_q)
							bed_pkg::MODE_FORCED: begin
								state_q <= ST_EVAL;
							end
							bed_pkg::MODE_PRESS: begin
								// unmatched press: flag it, then check the changed keys
								pending_q <= 1'b1;
								mode_q    <= bed_pkg::MODE_UNUSED;
								pat_q     <= chg_q;
								idx_q     <= '0;
							end
							bed_pkg::MODE_UNUSED: begin
								res_status_q <= bed_pkg::STATUS_ILLEGAL;
								res_beep_q   <= bed_pkg::BEEP_ERROR;
								state_q      <= ST_FINISH;
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign event_status = out_status_q;
	assign event_index  = out_idx_q;
	assign beep_kind    = out_beep_q;
	assign pending_flag = out_pending_q;

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the keypad event decoder
// Runs a short directed list against a hand-built event table, then seven
// phases of random key gestures, noise and forced events, each with its own
// table. Every result is checked, in order, against a cycle-free model of
// the decoder that is updated at each input transfer.
// ----------------------------------------------------------------------------
module testbench;
	import bed_pkg::*;

	// request code the block must treat as a no-op
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam int STALL_CYCLES = 300;    // long receiver hold-off
	localparam int PHASE_ITEMS  = 250;    // random requests per table
	localparam int DRAIN_CYCLES = 40;     // quiet wait after the last phase

	// one request as it sits on the input channel
	typedef struct packed {
		logic [1:0]       req;
		logic [KEY_W-1:0] first;
		logic [KEY_W-1:0] second;
		logic [KEY_W-1:0] fkeys;
		logic             fpress;
		logic             ftimed;
	} pad_req_t;

	// one decoded result
	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] index;
		logic [1:0]       beep;
		logic             pend;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           req_type = REQ_SAMPLE;
	logic [KEY_W-1:0]     sample_first = '0;
	logic [KEY_W-1:0]     sample_second = '0;
	logic [KEY_W-1:0]     forced_keys = '0;
	logic                 forced_press = 1'b0;
	logic                 forced_timed = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [1:0]           event_status;
	logic [IDX_W-1:0]     event_index;
	logic [1:0]           beep_kind;
	logic                 pending_flag;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_TABLE_LOW;
	logic [WORD_W-1:0]    cfg_data = '0;

	button_event_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.sample_first  (sample_first),
		.sample_second (sample_second),
		.forced_keys   (forced_keys),
		.forced_press  (forced_press),
		.forced_timed  (forced_timed),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_status  (event_status),
		.event_index   (event_index),
		.beep_kind     (beep_kind),
		.pending_flag  (pending_flag),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// requests waiting to be driven, and results owed by the block
	pad_req_t req_backlog[$];
	outcome_t expected_events[$];
	pad_req_t on_wire;

	// model copy of the decoder: table registers plus the three state items
	logic [WORD_W-1:0]  tbl_low = '0;
	logic [WORD_W-1:0]  tbl_high = '0;
	logic [PAT_W-1:0]   last_pat = '0;
	logic [TIMER_W-1:0] hold_tmr = '0;
	logic               pend_press = 1'b0;

	// bookkeeping
	int n_issued = 0;       // requests queued by the stimulus
	int n_accepted = 0;     // input transfers
	int n_done = 0;         // results matched against an expectation
	int n_errors = 0;
	int n_events = 0;
	int n_illegal = 0;
	int n_forced_hits = 0;
	int n_saturated = 0;
	int n_tables = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int stall_left = 0;
	int stalls_done = 0;
	int stalls_asked = 0;
	bit calm = 1'b0;        // no idling on either side

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Model of the decoder
	// ------------------------------------------------------------------

	// 16-bit table entry i out of the two configured words
	function automatic logic [ENTRY_W-1:0] entry_word(input int i);
		logic [WORD_W-1:0] w;
		w = (i < ENTRIES_PER_WORD) ? tbl_low : tbl_high;
		return w[ENTRY_W*(i % ENTRIES_PER_WORD) +: ENTRY_W];
	endfunction

	function automatic logic [KEY_W-1:0] keys_of(input logic [ENTRY_W-1:0] e);
		return e[KEY_W-1:0] & KEY_MASK;
	endfunction

	function automatic int secs_of(input logic [ENTRY_W-1:0] e);
		return int'(e[ENTRY_SECS_LSB +: SECS_W]);
	endfunction

	// Hold search: same keys, timed entry whose time has been reached.
	// An entry not yet due does not end the walk. A hit restarts the timer.
	function automatic int find_hold(input logic [KEY_W-1:0] pat);
		logic [ENTRY_W-1:0] e;
		for (int i = 0; i < EVENTS; i++) begin
			e = entry_word(i);
			if (keys_of(e) == '0)
				break;
			if (keys_of(e) == pat && secs_of(e) != 0 &&
			    int'(hold_tmr) >= secs_of(e) * TICKS_PER_SECOND) begin
				hold_tmr = '0;
				return i;
			end
		end
		return -1;
	endfunction

	// Press or release search; a timed release entry never fires here.
	// The noisy marker never equals an entry's keys.
	function automatic int find_edge(input logic [PAT_W-1:0] pat, input logic press);
		logic [ENTRY_W-1:0] e;
		for (int i = 0; i < EVENTS; i++) begin
			e = entry_word(i);
			if (keys_of(e) == '0)
				break;
			if ({1'b0, keys_of(e)} == pat && e[ENTRY_PRESS_BIT] == press &&
			    (press || secs_of(e) == 0))
				return i;
		end
		return -1;
	endfunction

	// true when no live entry covers every changed key
	function automatic bit keys_unused(input logic [PAT_W-1:0] changed);
		logic [ENTRY_W-1:0] e;
		for (int i = 0; i < EVENTS; i++) begin
			e = entry_word(i);
			if (keys_of(e) == '0)
				break;
			if (({1'b0, keys_of(e)} & changed) == changed)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic int find_forced(input logic [KEY_W-1:0] k, input logic press,
	                                   input logic timed);
		logic [ENTRY_W-1:0] e;
		for (int i = 0; i < EVENTS; i++) begin
			e = entry_word(i);
			if (keys_of(e) == '0)
				break;
			if (keys_of(e) == k && e[ENTRY_PRESS_BIT] == press &&
			    ((secs_of(e) != 0) == timed))
				return i;
		end
		return -1;
	endfunction

	// Advance the model by one accepted request and return what the block owes.
	function automatic outcome_t decode_request(input pad_req_t rq);
		outcome_t res;
		logic [KEY_W-1:0] a;
		logic [KEY_W-1:0] b;
		int hit;
		bit illegal;
		res = '{status: STATUS_NONE, index: '0, beep: BEEP_NONE, pend: 1'b0};
		if (rq.req == REQ_TICK) begin
			if (hold_tmr != TIMER_MAX)
				hold_tmr = hold_tmr + 1'b1;
			else
				n_saturated++;
		end else if (rq.req == REQ_SAMPLE || rq.req == REQ_FORCED) begin
			hit = -1;
			if (rq.req == REQ_FORCED)
				hit = find_forced(rq.fkeys & KEY_MASK, rq.fpress, rq.ftimed);
			if (hit >= 0) begin
				// forced match: sample skipped, state untouched, no beep
				res.status = STATUS_EVENT;
				res.index = IDX_W'(hit);
				n_forced_hits++;
			end else begin
				a = rq.first & KEY_MASK;
				b = rq.second & KEY_MASK;
				if (a != b) begin
					// bouncing keys: timer and pending press are kept
					last_pat = NOISY_MARK;
				end else begin
					illegal = 1'b0;
					if ({1'b0, a} == last_pat) begin
						if (a != '0)
							hit = find_hold(a);
					end else begin
						hold_tmr = '0;
						if ($countones(last_pat) < $countones(a)) begin
							hit = find_edge({1'b0, a}, 1'b1);
							if (hit < 0) begin
								pend_press = 1'b1;
								illegal = keys_unused(last_pat ^ {1'b0, a});
							end
						end else begin
							hit = find_edge(last_pat, 1'b0);
						end
					end
					if (hit >= 0) begin
						pend_press = 1'b0;
						res.status = STATUS_EVENT;
						res.index = IDX_W'(hit);
						res.beep = BEEP_NORMAL;
					end else if (illegal) begin
						res.status = STATUS_ILLEGAL;
						res.beep = BEEP_ERROR;
					end
					last_pat = {1'b0, a};
				end
			end
		end
		res.pend = pend_press;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic flag_mismatch(input string msg);
		n_errors++;
		$display("%0t: mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
	                           input logic [7:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s is %0d, expected %0d (result %0d)",
			                        name, got, want, n_done));
	endtask

	// ------------------------------------------------------------------
	// Driver: one request on the wire at a time, held until its transfer.
	// The model advances at the transfer, so expectations follow the
	// order in which the block took the requests.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_events.push_back(decode_request(on_wire));
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (req_backlog.size() > 0) begin
					on_wire = req_backlog.pop_front();
					req_type <= on_wire.req;
					sample_first <= on_wire.first;
					sample_second <= on_wire.second;
					forced_keys <= on_wire.fkeys;
					forced_press <= on_wire.fpress;
					forced_timed <= on_wire.ftimed;
					in_valid <= 1'b1;
					// short idle burst after this request, now and then
					if (!calm && $urandom_range(0, 4) == 0)
						send_gap = $urandom_range(1, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Long receiver hold-off, counted here so the monitor only looks at it
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_left <= 0;
			stalls_done <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (stalls_done != stalls_asked) begin
			stall_left <= STALL_CYCLES;
			stalls_done <= stalls_done + 1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compares each output transfer with the oldest expectation
	// and decides out_ready for the next cycle
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		outcome_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					flag_mismatch("result transfer with nothing expected");
				end else begin
					want = expected_events.pop_front();
					check_field("event_status", 8'(event_status), 8'(want.status));
					check_field("event_index", 8'(event_index), 8'(want.index));
					check_field("beep_kind", 8'(beep_kind), 8'(want.beep));
					check_field("pending_flag", 8'(pending_flag), 8'(want.pend));
					if (want.status == STATUS_EVENT)
						n_events++;
					if (want.status == STATUS_ILLEGAL)
						n_illegal++;
					n_done++;
				end
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 4) == 0)
					recv_gap = $urandom_range(1, 3);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic queue_req(input logic [1:0] req, input logic [KEY_W-1:0] first,
	                         input logic [KEY_W-1:0] second, input logic [KEY_W-1:0] fk,
	                         input logic fp, input logic ft);
		req_backlog.push_back('{req: req, first: first, second: second,
		                        fkeys: fk, fpress: fp, ftimed: ft});
		n_issued++;
	endtask

	// clean sample; the forced fields are don't-care and get random bits
	task automatic queue_sample(input logic [KEY_W-1:0] p);
		queue_req(REQ_SAMPLE, p, p, KEY_W'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic queue_ticks(input int n);
		for (int i = 0; i < n; i++)
			queue_req(REQ_TICK, KEY_W'($urandom), KEY_W'($urandom),
			          KEY_W'($urandom), 1'($urandom), 1'($urandom));
	endtask

	// Mostly patterns the table knows, so that searches hit
	function automatic logic [KEY_W-1:0] pick_keys();
		logic [ENTRY_W-1:0] e;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				e = entry_word($urandom_range(0, EVENTS - 1));
				return keys_of(e);
			end
			6, 7: return KEY_W'(1) << $urandom_range(0, KEYS - 1);
			default: return KEY_W'($urandom);
		endcase
	endfunction

	// press, maybe hold while ticks run, recheck, then release
	task automatic queue_gesture();
		logic [KEY_W-1:0] p;
		int nt;
		p = pick_keys();
		if ($urandom_range(0, 3) == 0)
			queue_sample(p & KEY_W'($urandom));
		queue_sample(p);
		case ($urandom_range(0, 19))
			0: nt = $urandom_range(240, 270);      // can run the timer into saturation
			1, 2, 3, 4, 5: nt = 0;
			default: nt = $urandom_range(1, 35);
		endcase
		queue_ticks(nt);
		queue_sample(p);
		if ($urandom_range(0, 2) == 0)
			queue_sample(p & KEY_W'($urandom));
		else
			queue_sample('0);
	endtask

	// two readings that disagree
	task automatic queue_noisy();
		logic [KEY_W-1:0] p;
		p = pick_keys();
		queue_req(REQ_SAMPLE, p, p ^ KEY_W'($urandom_range(1, (1 << KEY_W) - 1)),
		          KEY_W'($urandom), 1'($urandom), 1'($urandom));
	endtask

	// forced event built mostly from a real entry, with a sample behind it
	task automatic queue_forced();
		logic [ENTRY_W-1:0] e;
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] p;
		logic fp;
		logic ft;
		e = entry_word($urandom_range(0, EVENTS - 1));
		k = e[KEY_W-1:0];
		fp = e[ENTRY_PRESS_BIT];
		ft = (secs_of(e) != 0);
		if ($urandom_range(0, 3) == 0)
			k = KEY_W'($urandom);
		if ($urandom_range(0, 4) == 0)
			fp = 1'($urandom);
		if ($urandom_range(0, 4) == 0)
			ft = 1'($urandom);
		p = pick_keys();
		queue_req(REQ_FORCED, p, ($urandom_range(0, 4) == 0) ? KEY_W'($urandom) : p,
		          k, fp, ft);
	endtask

	// anything the ports allow, the unused request code included
	task automatic queue_junk();
		queue_req(2'($urandom_range(0, 3)), KEY_W'($urandom), KEY_W'($urandom),
		          KEY_W'($urandom), 1'($urandom), 1'($urandom));
	endtask

	// table writes happen only with the block idle
	task automatic load_table(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_TABLE_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= CFG_TABLE_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tbl_low = lo;
		tbl_high = hi;
		n_tables++;
	endtask

	// First 'live' entries usable, then, if room is left, an empty-keys terminator,
	// then junk the walk must never reach.
	task automatic random_table(input int live);
		logic [ENTRY_W-1:0] e;
		logic [2*WORD_W-1:0] t;
		for (int i = 0; i < EVENTS; i++) begin
			e = ENTRY_W'($urandom);
			if (i < live) begin
				case ($urandom_range(0, 3))
					0, 1: e[KEY_W-1:0] = KEY_W'(1) << $urandom_range(0, KEYS - 1);
					2: e[KEY_W-1:0] = KEY_W'(3) << $urandom_range(0, KEYS - 2);
					default: e[KEY_W-1:0] = KEY_W'($urandom_range(1, (1 << KEY_W) - 1));
				endcase
				e[ENTRY_PRESS_BIT] = ($urandom_range(0, 2) != 0);
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: e[ENTRY_SECS_LSB +: SECS_W] = '0;
					9: e[ENTRY_SECS_LSB +: SECS_W] = SECS_W'($urandom);
					default: e[ENTRY_SECS_LSB +: SECS_W] = SECS_W'($urandom_range(1, 3));
				endcase
			end else if (i == live) begin
				e[KEY_W-1:0] = '0;
			end
			t[ENTRY_W*i +: ENTRY_W] = e;
		end
		load_table(t[WORD_W-1:0], t[2*WORD_W-1:WORD_W]);
	endtask

	// wait until every request has its result, then let the clock run on quietly
	task automatic wait_drained();
		while (n_done < n_issued)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int phase_goal;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table:
		//   0: key0 press        1: key0 release      2: keys0-1 press
		//   3: key0 press, 1 s   4: key5 release, 2 s 5: all keys press
		//   6: empty (end of table)                   7: key1 press, unreachable
		load_table(64'h0181_0083_0001_0081, 64'h0082_0000_00BF_0220);
		queue_sample(6'h01);              // press of key0
		queue_ticks(10);                  // one second of holding
		queue_sample(6'h01);              // hold event due
		queue_sample(6'h00);              // release of key0
		queue_sample(6'h3F);              // every key pressed
		queue_sample(6'h20);              // release with no release entry
		queue_sample(6'h30);              // unmatched press, keys still covered
		queue_req(REQ_SAMPLE, 6'h10, 6'h20, 6'h3F, 1'b1, 1'b1);  // bouncing
		queue_sample(6'h02);              // noisy marker counts as a held key
		queue_req(REQ_SAMPLE, 6'h01, 6'h03, 6'h00, 1'b0, 1'b0);  // bouncing
		queue_sample(6'h0C);              // marker bit in the change: illegal
		queue_req(REQ_FORCED, 6'h3F, 6'h3F, 6'h01, 1'b1, 1'b1);  // timed press hit
		queue_req(REQ_FORCED, 6'h00, 6'h00, 6'h3F, 1'b1, 1'b0);  // all-keys hit
		queue_req(REQ_FORCED, 6'h15, 6'h2A, 6'h20, 1'b0, 1'b1);  // timed release hit
		queue_req(REQ_FORCED, 6'h00, 6'h00, 6'h02, 1'b1, 1'b0);  // past the end: miss
		queue_req(REQ_UNUSED, 6'h3F, 6'h3F, 6'h3F, 1'b1, 1'b1);
		queue_sample(6'h20);              // press with only a release entry
		queue_sample(6'h00);              // timed release never fires
		wait_drained();

		// Random phases, one table each. The first one also holds the output
		// off for a long stretch while requests keep coming.
		for (int ph = 1; ph <= 7; ph++) begin
			case (ph)
				1: random_table(EVENTS);
				2: load_table('1, '1);
				3: random_table($urandom_range(1, EVENTS - 1));
				4: load_table('0, '0);
				5: random_table(EVENTS);
				default: random_table($urandom_range(0, EVENTS));
			endcase
			if (ph == 7)
				calm = 1'b1;
			phase_goal = n_issued + PHASE_ITEMS;
			while (n_issued < phase_goal) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: queue_gesture();
					5: queue_noisy();
					6, 7: queue_forced();
					8: queue_junk();
					default: queue_ticks($urandom_range(1, 12));
				endcase
			end
			if (ph == 1)
				stalls_asked <= stalls_asked + 1;
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_events.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", expected_events.size()));

		$display("covered %0d requests over %0d event tables, %0d results checked",
		         n_accepted, n_tables, n_done);
		$display("  %0d table events (%0d forced), %0d illegal presses, %0d saturated ticks",
		         n_events, n_forced_hits, n_illegal, n_saturated);
		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[files.f]
rtl/core/bed_pkg.sv
rtl/core/bed_event_table.sv
rtl/core/bed_entry_match.sv
rtl/core/button_event_decoder.sv
verif/testbench.sv
